FILE: design/wrs_pkg.sv
// Shared constants, beat types and control types for the weighted roulette selector.
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int WEIGHT_BITS = 32;
    localparam int FRAC_BITS   = 32;
    localparam int TOTAL_BITS  = WEIGHT_BITS + SLOT_BITS;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic STAT_DONE  = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  slot_index;
        logic [31:0] weight;
        logic [31:0] random_fraction;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] chosen_slot;
        logic       status;
    } t_out_beat;

    typedef struct packed {
        logic                   wr_en;
        logic [SLOT_BITS-1:0]   wr_addr;
        logic [WEIGHT_BITS-1:0] wr_data;
        logic                   rd_en;
        logic [SLOT_BITS-1:0]   rd_addr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_UPD,
        S_MUL,
        S_ADD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/weighted_roulette_selector.sv
// Top level of the weighted roulette selector.
//
//  channel  dir  handshake                    beat
//  in       in   i_in_valid / o_in_stall      t_in_beat  (op, slot, weight, fraction)
//  out      out  o_out_valid / i_out_stall    t_out_beat (chosen_slot, status)
//
//  Write: table read, update, result load.
//  Sample: target computation, then a linear scan from slot 0 up to the chosen slot;
//  one table read per cycle on the single read port sets the scan rate.
//  Sample with zero total: no scan; an empty result is loaded.
//  Reset clears the total and the per-slot valid bits; no clearing pass.
//  Input is stalled while an item is in work; a waiting result beat holds
//  until taken and blocks only the completion of the following item.
`timescale 1ns / 1ps
`default_nettype none

module weighted_roulette_selector
    import wrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    t_ram_req               ram_req;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic [FRAC_BITS-1:0]   frac;
    logic [TOTAL_BITS-1:0]  total;
    logic [TOTAL_BITS-1:0]  target;

    wrs_weight_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    wrs_target u_target (
        .i_clk    (i_clk),
        .i_frac   (frac),
        .i_total  (total),
        .o_target (target)
    );

    wrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_ram_req   (ram_req),
        .i_rd_data   (rd_data),
        .o_frac      (frac),
        .o_total     (total),
        .i_target    (target)
    );

    // an accepted write updates its slot in the next cycle
    a_write_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == OP_WRITE) |=>
        (ram_req.wr_en && ram_req.wr_addr == $past(i_in_data.slot_index)))
        else $error("write beat not applied to table");

    // table writes only happen while an item is in work
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> o_in_stall)
        else $error("table write outside item");

    // a new result beat only follows an item in work
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without item");

endmodule

`default_nettype wire

FILE: design/wrs_weight_ram.sv
// Weight table: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module wrs_weight_ram
    import wrs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ram_req               i_req,
    output logic [WEIGHT_BITS-1:0]      o_rd_data
);

    logic [WEIGHT_BITS-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]       r_vld;
    logic [WEIGHT_BITS-1:0] r_q;
    logic                   r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

`default_nettype wire

FILE: design/wrs_target.sv
// Two-stage target computation: floor(fraction * total / 2^32).
`timescale 1ns / 1ps
`default_nettype none

module wrs_target
    import wrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [FRAC_BITS-1:0]  i_frac,
    input  wire logic [TOTAL_BITS-1:0] i_total,
    output logic [TOTAL_BITS-1:0]      o_target
);

    logic [2*FRAC_BITS-1:0]            r_plo;
    logic [TOTAL_BITS-1:0]             r_phi;
    logic [TOTAL_BITS-1:0]             r_target;

    // stage 1: split the total into a low word and the high slot bits, and multiply each by the fraction
    always_ff @(posedge i_clk) begin
        r_plo <= i_frac * i_total[FRAC_BITS-1:0];
        r_phi <= i_frac * i_total[TOTAL_BITS-1:FRAC_BITS];
    end

    // stage 2: result stays below the total, so it fits TOTAL_BITS
    always_ff @(posedge i_clk) begin
        r_target <= r_phi + TOTAL_BITS'(r_plo[2*FRAC_BITS-1:FRAC_BITS]);
    end

    assign o_target = r_target;

endmodule

`default_nettype wire

FILE: design/wrs_ctrl.sv
// Sequencer: weight update read-modify-write, linear scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module wrs_ctrl
    import wrs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in_beat               i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_beat                   o_out_data,
    output t_ram_req                    o_ram_req,
    input  wire logic [WEIGHT_BITS-1:0] i_rd_data,
    output logic [FRAC_BITS-1:0]        o_frac,
    output logic [TOTAL_BITS-1:0]       o_total,
    input  wire logic [TOTAL_BITS-1:0]  i_target
);

    t_state                 r_state, n_state;
    logic [SLOT_BITS-1:0]   r_idx;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [FRAC_BITS-1:0]   r_frac;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [TOTAL_BITS-1:0]  r_cum;
    logic [SLOT_BITS-1:0]   r_scan_idx;
    t_out_beat              r_res;
    t_out_beat              r_out;
    logic                   r_out_valid;

    logic                   accept;
    logic [TOTAL_BITS-1:0]  cum_sum;
    logic                   found;
    logic                   last;
    logic                   out_load;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign cum_sum  = r_cum + TOTAL_BITS'(i_rd_data);
    assign found    = i_target < cum_sum;
    assign last     = r_scan_idx == SLOT_BITS'(SLOTS - 1);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.op == OP_WRITE) begin
                        n_state = S_WR_UPD;
                    end else if (r_total == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_WR_UPD: n_state = S_DONE;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_SCAN;
            S_SCAN: begin
                if (found || last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ram_req         = '0;
        o_ram_req.wr_addr = r_idx;
        o_ram_req.wr_data = r_w;
        unique case (r_state)
            S_IDLE: begin
                o_ram_req.rd_en   = accept;
                o_ram_req.rd_addr = i_in_data.slot_index[SLOT_BITS-1:0];
            end
            S_WR_UPD: o_ram_req.wr_en = 1'b1;
            S_ADD: begin
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = '0;
            end
            S_SCAN: begin
                // prefetch the next slot while this one is summed
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = r_scan_idx + 1'b1;
            end
            S_MUL, S_DONE: o_ram_req.rd_en = 1'b0;
            default:       o_ram_req.rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WR_UPD) begin
                r_total <= r_total - TOTAL_BITS'(i_rd_data) + TOTAL_BITS'(r_w);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= i_in_data.slot_index[SLOT_BITS-1:0];
            r_w    <= i_in_data.weight[WEIGHT_BITS-1:0];
            r_frac <= i_in_data.random_fraction;
            r_res  <= '{chosen_slot: 8'd0, status: STAT_EMPTY};
        end
        if (r_state == S_WR_UPD) begin
            r_res <= '{chosen_slot: 8'(r_idx), status: STAT_DONE};
        end
        if (r_state == S_ADD) begin
            r_cum      <= '0;
            r_scan_idx <= '0;
        end
        if (r_state == S_SCAN) begin
            r_cum      <= cum_sum;
            r_scan_idx <= r_scan_idx + 1'b1;
            if (found) begin
                r_res <= '{chosen_slot: 8'(r_scan_idx), status: STAT_DONE};
            end else begin
                r_res <= '{chosen_slot: 8'd0, status: STAT_EMPTY};
            end
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_frac      = r_frac;
    assign o_total     = r_total;

endmodule

`default_nettype wire
